// File: src/ubx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ubx_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [7:0] TARGET_CLASS_RESET = 8'd10;
    localparam logic [7:0] TARGET_ID_RESET    = 8'd4;

    // configuration register indexes
    localparam logic [7:0] CFG_TARGET_CLASS = 8'd0;
    localparam logic [7:0] CFG_TARGET_ID    = 8'd1;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_MATCH    = 2'd1,
        EV_OTHER    = 2'd2,
        EV_CK_FAIL  = 2'd3
    } t_event;

    typedef enum logic [8:0] {
        PH_SYNC1   = 9'b000000001,
        PH_SYNC2   = 9'b000000010,
        PH_CLASS   = 9'b000000100,
        PH_ID      = 9'b000001000,
        PH_LEN_LO  = 9'b000010000,
        PH_LEN_HI  = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CK_A    = 9'b010000000,
        PH_CK_B    = 9'b100000000
    } t_phase;

    typedef struct packed {
        t_event      event_code;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        logic [15:0] payload_length;
        logic        payload_valid;
        logic [7:0]  payload_data;
        logic [15:0] payload_index;
    } t_result;

endpackage

`default_nettype wire

// File: src/ubx_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module ubx_parser import ubx_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [7:0]  i_target_class,
    input  wire logic [7:0]  i_target_id,
    output t_result          o_result
);

    t_phase      r_phase,  n_phase;
    logic [7:0]  r_sum_a,  n_sum_a;
    logic [7:0]  r_sum_b,  n_sum_b;
    logic [7:0]  r_class,  n_class;
    logic [7:0]  r_id,     n_id;
    logic [15:0] r_length, n_length;
    logic [15:0] r_count,  n_count;

    logic [7:0]  w_add_a;
    logic [7:0]  w_add_b;
    logic [15:0] w_count_inc;

    // Fletcher step on the incoming byte
    assign w_add_a     = r_sum_a + i_rx_byte;
    assign w_add_b     = r_sum_b + w_add_a;
    assign w_count_inc = r_count + 16'd1;

    always_comb begin
        n_phase  = r_phase;
        n_sum_a  = r_sum_a;
        n_sum_b  = r_sum_b;
        n_class  = r_class;
        n_id     = r_id;
        n_length = r_length;
        n_count  = r_count;
        o_result.event_code    = EV_NONE;
        o_result.payload_valid = 1'b0;
        o_result.payload_data  = 8'd0;
        o_result.payload_index = 16'd0;
        case (r_phase)
            PH_SYNC2: begin
                if (i_rx_byte == SYNC_SECOND) begin
                    n_phase = PH_CLASS;
                    n_sum_a = 8'd0;
                    n_sum_b = 8'd0;
                end else if (i_rx_byte != SYNC_FIRST) begin
                    n_phase = PH_SYNC1;
                end
            end
            PH_CLASS: begin
                n_class = i_rx_byte;
                n_sum_a = w_add_a;
                n_sum_b = w_add_b;
                n_phase = PH_ID;
            end
            PH_ID: begin
                n_id    = i_rx_byte;
                n_sum_a = w_add_a;
                n_sum_b = w_add_b;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_length = {8'd0, i_rx_byte};
                n_sum_a  = w_add_a;
                n_sum_b  = w_add_b;
                n_phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_length = {i_rx_byte, r_length[7:0]};
                n_sum_a  = w_add_a;
                n_sum_b  = w_add_b;
                n_count  = 16'd0;
                n_phase  = (n_length == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                o_result.payload_valid = 1'b1;
                o_result.payload_data  = i_rx_byte;
                o_result.payload_index = r_count;
                n_sum_a = w_add_a;
                n_sum_b = w_add_b;
                n_count = w_count_inc;
                if (w_count_inc >= r_length) begin
                    n_phase = PH_CK_A;
                end
            end
            PH_CK_A: begin
                if (i_rx_byte == r_sum_a) begin
                    n_phase = PH_CK_B;
                end else begin
                    o_result.event_code = EV_CK_FAIL;
                    n_phase = PH_SYNC1;
                end
            end
            PH_CK_B: begin
                if (i_rx_byte != r_sum_b) begin
                    o_result.event_code = EV_CK_FAIL;
                end else if (r_class == i_target_class && r_id == i_target_id) begin
                    o_result.event_code = EV_MATCH;
                end else begin
                    o_result.event_code = EV_OTHER;
                end
                n_phase = PH_SYNC1;
            end
            default: begin
                n_phase = (i_rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
        o_result.frame_class    = n_class;
        o_result.frame_id       = n_id;
        o_result.payload_length = n_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SYNC1;
            r_sum_a  <= 8'd0;
            r_sum_b  <= 8'd0;
            r_class  <= 8'd0;
            r_id     <= 8'd0;
            r_length <= 16'd0;
            r_count  <= 16'd0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_sum_a  <= n_sum_a;
            r_sum_b  <= n_sum_b;
            r_class  <= n_class;
            r_id     <= n_id;
            r_length <= n_length;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: src/ubx_frame_receiver.sv
// UBX frame receiver.
// Input channel (i_valid / o_ready / i_rx_byte): one received serial byte
// per item. Output channel (o_valid / i_ready / o_*): exactly one result item
// per byte, carrying the frame's class, id and declared length, the payload
// byte with its index when the byte was payload, and on the last checksum
// byte (or a bad first checksum byte) the frame outcome: match, other, fail.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 writes target_class,
// index 1 target_id; other indexes are ignored. Always ready; write only
// while idle.
// The result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle when not stalled, set by the single-pass
// parser between the frame state registers and the output register.
// Stall: the output register holds its item while i_ready is low; o_ready
// then drops, and rises again in the cycle the held item is taken, so a
// byte is accepted in the same cycle as the result is drained.
// Reset (synchronous, active low): parser waits for the first sync byte,
// sums and held fields are cleared, targets return to class 0x0A id 0x04,
// and the output register is emptied.
`timescale 1ns / 1ps
`default_nettype none

module ubx_frame_receiver import ubx_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    // result output
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_frame_event,
    output logic [7:0]       o_frame_class,
    output logic [7:0]       o_frame_id,
    output logic [15:0]      o_payload_length,
    output logic             o_payload_valid,
    output logic [7:0]       o_payload_data,
    output logic [15:0]      o_payload_index,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    logic [7:0] r_target_class;
    logic [7:0] r_target_id;
    t_result    r_out;
    logic       r_out_valid;
    t_result    w_result;
    logic       w_take;

    // free output slot, or the held item leaves this cycle
    assign o_ready     = !r_out_valid || i_ready;
    assign w_take      = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    ubx_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (w_take),
        .i_rx_byte      (i_rx_byte),
        .i_target_class (r_target_class),
        .i_target_id    (r_target_id),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_class <= TARGET_CLASS_RESET;
            r_target_id    <= TARGET_ID_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TARGET_CLASS) begin
                r_target_class <= i_cfg_data;
            end else if (i_cfg_index == CFG_TARGET_ID) begin
                r_target_id <= i_cfg_data;
            end
        end
    end

    // output register: valid is control, payload loads on accept only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_frame_event    = r_out.event_code;
    assign o_frame_class    = r_out.frame_class;
    assign o_frame_id       = r_out.frame_id;
    assign o_payload_length = r_out.payload_length;
    assign o_payload_valid  = r_out.payload_valid;
    assign o_payload_data   = r_out.payload_data;
    assign o_payload_index  = r_out.payload_index;

endmodule

`default_nettype wire

// File: src/ubx_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ubx_checker import ubx_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [1:0]  i_frame_event,
    input  wire logic [15:0] i_payload_length,
    input  wire logic        i_payload_valid,
    input  wire logic [7:0]  i_payload_data,
    input  wire logic [15:0] i_payload_index
);

    // payload bytes never coincide with a frame outcome
    a_payload_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_payload_valid |-> i_frame_event == EV_NONE)
        else $error("payload item carries a frame event");

    // non-payload items carry zero data and index
    a_idle_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_payload_valid |-> i_payload_data == 8'd0 && i_payload_index == 16'd0)
        else $error("payload data or index set without payload_valid");

    // index stays within the declared length
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_payload_valid |-> i_payload_index < i_payload_length)
        else $error("payload index beyond declared length");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_frame_event)
            && $stable(i_payload_index))
        else $error("stalled result changed");

endmodule

bind ubx_frame_receiver ubx_checker u_ubx_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_valid),
    .i_out_ready      (i_ready),
    .i_frame_event    (o_frame_event),
    .i_payload_length (o_payload_length),
    .i_payload_valid  (o_payload_valid),
    .i_payload_data   (o_payload_data),
    .i_payload_index  (o_payload_index)
);

`default_nettype wire

// File: bench/ubx_frame_receiver_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the UBX frame receiver.
// Byte items go in through a valid/ready driver fed from a queue; every accepted byte is
// run through a local copy of the frame parser and its result item is queued. A monitor
// takes result items off the output channel and compares them field by field, oldest
// first. Target class and id are rewritten between phases, only once the block is idle.
module ubx_frame_receiver_tb;
    import ubx_pkg::*;

    localparam int IDLE_LIMIT  = 4000;   // cycles with no handshake on any channel
    localparam int HOLD_CYCLES = 250;    // long receiver hold-off, fills the block
    localparam int MAX_REPORTS = 40;

    typedef enum {FR_GOOD, FR_BAD_CK_A, FR_BAD_CK_B} t_flaw;
    typedef enum {SEND_STREAM, SEND_BURSTS} t_send_mode;
    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SLOW} t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_rx_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_frame_event;
    logic [7:0]  o_frame_class;
    logic [7:0]  o_frame_id;
    logic [15:0] o_payload_length;
    logic        o_payload_valid;
    logic [7:0]  o_payload_data;
    logic [15:0] o_payload_index;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    // stimulus and scoreboard
    logic [7:0]  byte_q[$];
    t_result     result_q[$];
    int          pushed_total = 0;
    int          results_seen = 0;
    int          error_count = 0;
    logic [7:0]  last_pushed = '0;

    // traffic shaping
    t_send_mode  send_mode = SEND_BURSTS;
    t_rx_mode    ready_mode = RX_RANDOM;
    int          burst_left = 0;
    int          gap_left = 0;
    logic        want_hold = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int          rx_tick = 0;
    int          idle_cycles = 0;

    // parser copy: register view and frame state
    logic [7:0]  tgt_class = TARGET_CLASS_RESET;
    logic [7:0]  tgt_id = TARGET_ID_RESET;
    t_phase      ph = PH_SYNC1;
    logic [7:0]  ck_a = '0;
    logic [7:0]  ck_b = '0;
    logic [7:0]  cur_class = '0;
    logic [7:0]  cur_id = '0;
    logic [15:0] cur_len = '0;
    logic [15:0] pay_cnt = '0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    ubx_frame_receiver u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_frame_event    (o_frame_event),
        .o_frame_class    (o_frame_class),
        .o_frame_id       (o_frame_id),
        .o_payload_length (o_payload_length),
        .o_payload_valid  (o_payload_valid),
        .o_payload_data   (o_payload_data),
        .o_payload_index  (o_payload_index),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // 8-bit Fletcher running sums over class, id, length and payload
    function automatic void fletcher_add(input logic [7:0] c);
        ck_a = ck_a + c;
        ck_b = ck_b + ck_a;
    endfunction

    // Advances the parser copy by one byte and returns the result item it yields.
    function automatic t_result parse_byte(input logic [7:0] c);
        t_result r;
        r = '0;
        case (ph)
            PH_SYNC2: begin
                if (c == SYNC_SECOND) begin
                    ph = PH_CLASS;
                    ck_a = '0;
                    ck_b = '0;
                end else if (c != SYNC_FIRST) begin
                    ph = PH_SYNC1;   // a repeated 0xB5 keeps waiting here
                end
            end
            PH_CLASS: begin
                cur_class = c;
                fletcher_add(c);
                ph = PH_ID;
            end
            PH_ID: begin
                cur_id = c;
                fletcher_add(c);
                ph = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                cur_len = {8'h00, c};
                fletcher_add(c);
                ph = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                cur_len = cur_len | {c, 8'h00};
                fletcher_add(c);
                pay_cnt = '0;
                ph = (cur_len == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                r.payload_valid = 1'b1;
                r.payload_data  = c;
                r.payload_index = pay_cnt;
                fletcher_add(c);
                pay_cnt = pay_cnt + 16'd1;
                if (pay_cnt >= cur_len) ph = PH_CK_A;
            end
            PH_CK_A: begin
                // a bad first check byte ends the frame at once; it is not a sync byte
                if (c == ck_a) begin
                    ph = PH_CK_B;
                end else begin
                    r.event_code = EV_CK_FAIL;
                    ph = PH_SYNC1;
                end
            end
            PH_CK_B: begin
                if (c != ck_b) r.event_code = EV_CK_FAIL;
                else if (cur_class == tgt_class && cur_id == tgt_id) r.event_code = EV_MATCH;
                else r.event_code = EV_OTHER;
                ph = PH_SYNC1;
            end
            default: begin
                ph = (c == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
        // held fields carry over between frames
        r.frame_class    = cur_class;
        r.frame_id       = cur_id;
        r.payload_length = cur_len;
        return r;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("ERROR result %0d: %s", results_seen, msg);
    endtask

    task automatic put_byte(input logic [7:0] v);
        byte_q.push_back(v);
        last_pushed = v;
        pushed_total++;
    endtask

    // Whole frame with its own checksum; fill < 0 gives a random payload.
    task automatic push_frame(input logic [7:0] cls, input logic [7:0] id, input int len,
                              input t_flaw flaw, input int fill);
        logic [7:0] sa;
        logic [7:0] sb;
        logic [7:0] v;
        sa = '0;
        sb = '0;
        put_byte(SYNC_FIRST);
        put_byte(SYNC_SECOND);
        for (int k = -4; k < len; k++) begin
            case (k)
                -4: v = cls;
                -3: v = id;
                -2: v = len[7:0];
                -1: v = len[15:8];
                default: begin
                    if (fill >= 0) v = fill[7:0];
                    else if ($urandom_range(0, 9) == 0) v = SYNC_FIRST;
                    else v = 8'($urandom_range(0, 255));
                end
            endcase
            sa = sa + v;
            sb = sb + sa;
            put_byte(v);
        end
        case (flaw)
            FR_GOOD: begin
                put_byte(sa);
                put_byte(sb);
            end
            FR_BAD_CK_A: begin
                // now and then the bad byte is 0xB5, which must not restart sync
                if (sa != SYNC_FIRST && $urandom_range(0, 3) == 0) v = SYNC_FIRST;
                else v = sa ^ 8'($urandom_range(1, 255));
                put_byte(v);
            end
            default: begin
                put_byte(sa);
                put_byte(sb ^ 8'($urandom_range(1, 255)));
            end
        endcase
    endtask

    // Line noise between frames, heavy on 0xB5, never a complete sync pair.
    task automatic push_noise(input int n);
        logic [7:0] v;
        repeat (n) begin
            v = ($urandom_range(0, 2) == 0) ? SYNC_FIRST : 8'($urandom_range(0, 255));
            if (last_pushed == SYNC_FIRST && v == SYNC_SECOND) v = SYNC_SECOND + 8'd1;
            put_byte(v);
        end
    endtask

    // Mostly well-formed frames, biased towards the current target, plus
    // corrupted check bytes and noise.
    task automatic random_traffic(input int n);
        int stop_at;
        int pick;
        int len;
        logic [7:0] cls;
        logic [7:0] id;
        stop_at = pushed_total + n;
        while (pushed_total < stop_at) begin
            pick = $urandom_range(0, 99);
            cls = (pick < 55) ? tgt_class : 8'($urandom_range(0, 255));
            id  = (pick < 40 || (pick >= 55 && pick < 65)) ? tgt_id
                                                            : 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 70) len = $urandom_range(0, 6);
            else if (pick < 97) len = $urandom_range(7, 40);
            else len = $urandom_range(250, 260);
            pick = $urandom_range(0, 99);
            if (pick < 62) push_frame(cls, id, len, FR_GOOD, -1);
            else if (pick < 74) push_frame(cls, id, len, FR_BAD_CK_A, -1);
            else if (pick < 86) push_frame(cls, id, len, FR_BAD_CK_B, -1);
            else push_noise($urandom_range(1, 6));
        end
    endtask

    // Valid is held across back-to-back writes and dropped once after the last one.
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == CFG_TARGET_CLASS) tgt_class = val;
        else if (idx == CFG_TARGET_ID) tgt_id = val;
    endtask

    task automatic set_targets(input logic [7:0] cls, input logic [7:0] id);
        write_reg(CFG_TARGET_CLASS, cls);
        write_reg(CFG_TARGET_ID, id);
        i_cfg_valid <= 1'b0;
    endtask

    // idle once every byte queued so far has produced its result item
    task automatic wait_idle();
        do @(posedge i_clk); while (results_seen != pushed_total);
    endtask

    task automatic run_phase(input logic [7:0] cls, input logic [7:0] id,
                             input t_send_mode smode, input t_rx_mode rmode,
                             input int n, input logic hold);
        set_targets(cls, id);
        send_mode  <= smode;
        ready_mode <= rmode;
        random_traffic(n);
        if (hold) want_hold <= 1'b1;
        wait_idle();
    endtask

    // Byte driver: bursts of random length with random gaps, or a steady stream.
    // Every accepted byte goes through the parser copy here, in acceptance order.
    always @(posedge i_clk) begin
        if (i_valid && o_ready) result_q.push_back(parse_byte(i_rx_byte));
        if (!i_valid || o_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (i_rst_n && byte_q.size() > 0) begin
                i_valid   <= 1'b1;
                i_rx_byte <= byte_q.pop_front();
                if (send_mode == SEND_BURSTS) begin
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result sink. The long hold-off is counted here; while it lasts the
    // driver keeps offering, so the output register fills and o_ready drops.
    always @(posedge i_clk) begin
        logic rdy;
        rx_tick++;
        if (want_hold && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else begin
            case (ready_mode)
                RX_ALWAYS:  rdy = 1'b1;
                RX_RANDOM:  rdy = ($urandom_range(0, 3) != 0);
                RX_PATTERN: rdy = ((rx_tick % 11) < 7);
                default:    rdy = ($urandom_range(0, 9) < 3);
            endcase
        end
        i_ready <= rdy;
    end

    // Monitor: one check per result item, oldest expectation first.
    always @(posedge i_clk) begin
        t_result want;
        if (o_valid === 1'b1 && i_ready) begin
            results_seen++;
            if (result_q.size() == 0) begin
                report_error($sformatf("result item with nothing pending, event %0d",
                                       o_frame_event));
            end else begin
                want = result_q.pop_front();
                if (o_frame_event !== want.event_code)
                    report_error($sformatf("frame_event got %0d want %0d",
                                           o_frame_event, want.event_code));
                if (o_frame_class !== want.frame_class)
                    report_error($sformatf("frame_class got %h want %h",
                                           o_frame_class, want.frame_class));
                if (o_frame_id !== want.frame_id)
                    report_error($sformatf("frame_id got %h want %h",
                                           o_frame_id, want.frame_id));
                if (o_payload_length !== want.payload_length)
                    report_error($sformatf("payload_length got %0d want %0d",
                                           o_payload_length, want.payload_length));
                if (o_payload_valid !== want.payload_valid)
                    report_error($sformatf("payload_valid got %b want %b",
                                           o_payload_valid, want.payload_valid));
                if (o_payload_data !== want.payload_data)
                    report_error($sformatf("payload_data got %h want %h",
                                           o_payload_data, want.payload_data));
                if (o_payload_index !== want.payload_index)
                    report_error($sformatf("payload_index got %0d want %0d",
                                           o_payload_index, want.payload_index));
            end
        end
    end

    // Watchdog: too long without any handshake means the block has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ubx_frame_receiver_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        // lost sync: bad first check byte equal to 0xB5, then a 0x62 that must be ignored
        logic [7:0] lost_sync[8] = '{SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h00, 8'h00, 8'h00,
                                     SYNC_FIRST, SYNC_SECOND};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: repeated sync into an empty matching frame at reset targets,
        // all-ones class/id/payload, then the lost-sync case
        put_byte(SYNC_FIRST);
        push_frame(TARGET_CLASS_RESET, TARGET_ID_RESET, 0, FR_GOOD, -1);
        push_frame(8'hFF, 8'hFF, 1, FR_GOOD, 8'hFF);
        foreach (lost_sync[k]) put_byte(lost_sync[k]);
        random_traffic(80);
        wait_idle();

        // target settings across the range, each with its own traffic shape
        run_phase(8'h00, 8'h00, SEND_STREAM, RX_ALWAYS, 80, 1'b0);
        run_phase(8'hFF, 8'hFF, SEND_BURSTS, RX_PATTERN, 90, 1'b1);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  SEND_BURSTS, RX_SLOW, 70, 1'b0);
        run_phase(SYNC_FIRST, SYNC_SECOND, SEND_STREAM, RX_RANDOM, 80, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  SEND_BURSTS, RX_RANDOM, 70, 1'b0);

        // long payload: length carry into the high byte
        set_targets(TARGET_CLASS_RESET, TARGET_ID_RESET);
        send_mode  <= SEND_STREAM;
        ready_mode <= RX_ALWAYS;
        push_frame(TARGET_CLASS_RESET, TARGET_ID_RESET, 256, FR_GOOD, -1);
        random_traffic(10);
        wait_idle();

        // results are registered; waiting on past idle catches any stray result item
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ubx_frame_receiver_tb: clean");
        end else begin
            $display("ubx_frame_receiver_tb: errors");
        end
        $finish;
    end

endmodule
